// ===== src/lbmav_pkg.sv =====
// Package for the D2Q9 average velocity block: field widths, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbmav_pkg;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned RhoW   = 20;
  localparam int unsigned MomW   = 18;
  localparam int unsigned UW     = 17;
  localparam int unsigned MagW   = 17;
  localparam int unsigned SumW   = 37;
  localparam int unsigned CountW = 21;
  localparam int unsigned AvgW   = 17;
  localparam int unsigned ReW    = 32;
  localparam int unsigned HeightW = 13;
  localparam int unsigned ViscW  = 16;
  localparam int unsigned Dirs   = 9;
  // At most this many fluid cells are counted per grid; later fluid cells are ignored.
  localparam int unsigned MaxCells = 1048576;

  localparam logic [1:0] CfgHeight = 2'd0;
  localparam logic [1:0] CfgVisc   = 2'd1;

  // Per-lane divider job: numerator and divisor.
  typedef struct packed {
    logic [MomW+16-1:0] num;
    logic [RhoW-1:0]    den;
  } div_job_t;
endpackage
`default_nettype wire

// ===== src/lbm_d2q9_average_velocity.sv =====
// D2Q9 average velocity top level: cell front end, x and y divider lanes,
// magnitude unit, accumulator and the end-of-grid report with the average
// and Reynolds dividers. Depends on lbmav_pkg, lbmav_divlane, lbmav_sqrt.
`timescale 1ns / 1ps
`default_nettype none
// One cell is taken per transaction. A counted fluid cell runs through the
// sums, the x and y divider lanes side by side (one quotient bit at a time),
// the square and the bit-serial square root, then the accumulate. A last
// cell also runs the average divider and the Reynolds divider, unless no
// fluid cell was counted. The result sits in an output register; the next
// cell is taken while it waits.
module lbm_d2q9_average_velocity (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] speed_0_i,
  input  wire logic [15:0] speed_1_i,
  input  wire logic [15:0] speed_2_i,
  input  wire logic [15:0] speed_3_i,
  input  wire logic [15:0] speed_4_i,
  input  wire logic [15:0] speed_5_i,
  input  wire logic [15:0] speed_6_i,
  input  wire logic [15:0] speed_7_i,
  input  wire logic [15:0] speed_8_i,
  input  wire logic        is_obstacle_i,
  input  wire logic        last_cell_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [16:0]      average_speed_o,
  output logic [31:0]      reynolds_number_o,
  output logic [20:0]      fluid_cells_o,
  output logic             no_fluid_o
);
  localparam int unsigned SumW = lbmav_pkg::SumW;
  localparam int unsigned CountW = lbmav_pkg::CountW;
  localparam int unsigned NumW = lbmav_pkg::MomW + 16;
  localparam int unsigned RhoW = lbmav_pkg::RhoW;
  localparam int unsigned ReNumW = 17 + 13 + 16;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_SQ    = 7'b0000100,
    S_SQRT  = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_AVG   = 7'b0100000,
    S_RE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [12:0] height_q;
  logic [15:0] visc_q;
  logic [SumW-1:0] sum_q;
  logic [CountW-1:0] count_q;
  logic fluid_q, last_q, zero_q, start_q;
  logic [16:0] ux_q, uy_q;
  logic [35:0] sq_q;
  logic [16:0] avg_q;
  logic [29:0] prod_q;
  logic out_valid_q;
  logic [16:0] out_avg_q;
  logic [31:0] out_re_q;
  logic [CountW-1:0] out_cnt_q;
  logic out_nf_q;

  logic [RhoW-1:0] rho;
  logic [17:0] xp, xn, yp, yn;
  lbmav_pkg::div_job_t jx, jy;
  logic accept, dx_done, dy_done, sq_done, ad_done, rd_done;
  logic [NumW-1:0] qx, qy;
  logic [16:0] mag;
  logic [SumW-1:0] ad_q;
  logic [ReNumW-1:0] rd_q;
  logic sq_start, ad_start, rd_start, dv_start;
  logic [SumW:0] sum_ext;
  logic cnt_ok;

  assign accept = in_valid_i && in_ready_o;
  assign cnt_ok = {11'd0, count_q} < 32'(lbmav_pkg::MaxCells);
  assign in_ready_o = (state_q == S_IDLE) && !start_q;

  // Front end: density and direction sums.
  always_comb begin
    rho = RhoW'(speed_0_i) + RhoW'(speed_1_i) + RhoW'(speed_2_i) +
          RhoW'(speed_3_i) + RhoW'(speed_4_i) + RhoW'(speed_5_i) +
          RhoW'(speed_6_i) + RhoW'(speed_7_i) + RhoW'(speed_8_i);
    xp = 18'(speed_1_i) + 18'(speed_5_i) + 18'(speed_8_i);
    xn = 18'(speed_3_i) + 18'(speed_6_i) + 18'(speed_7_i);
    yp = 18'(speed_2_i) + 18'(speed_5_i) + 18'(speed_6_i);
    yn = 18'(speed_4_i) + 18'(speed_7_i) + 18'(speed_8_i);
    jx.num = {(xp >= xn) ? xp - xn : xn - xp, 16'd0};
    jy.num = {(yp >= yn) ? yp - yn : yn - yp, 16'd0};
    jx.den = (rho == '0) ? RhoW'(1) : rho;
    jy.den = jx.den;
  end

  assign dv_start = accept && !is_obstacle_i && cnt_ok;

  lbmav_divlane #(.NumW(NumW), .DenW(RhoW)) u_div_x (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(jx.num), .den_i(jx.den),
    .done_o(dx_done), .quo_o(qx)
  );
  lbmav_divlane #(.NumW(NumW), .DenW(RhoW)) u_div_y (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(jy.num), .den_i(jy.den),
    .done_o(dy_done), .quo_o(qy)
  );

  // Start the root once the square has landed in sq_q.
  assign sq_start = start_q && (state_q == S_SQRT);
  lbmav_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_q), .done_o(sq_done),
    .root_o(mag)
  );

  // Average and Reynolds dividers, separate instances of the divider lane.
  assign ad_start = start_q && (state_q == S_AVG);
  lbmav_divlane #(.NumW(SumW), .DenW(CountW)) u_div_avg (
    .clk_i, .rst_ni, .start_i(ad_start), .num_i(sum_q), .den_i(count_q),
    .done_o(ad_done), .quo_o(ad_q)
  );
  assign rd_start = start_q && (state_q == S_RE);
  lbmav_divlane #(.NumW(ReNumW), .DenW(16)) u_div_re (
    .clk_i, .rst_ni, .start_i(rd_start), .num_i({prod_q, 16'd0}),
    .den_i(visc_q), .done_o(rd_done), .quo_o(rd_q)
  );

  assign sum_ext = {1'b0, sum_q} + (SumW + 1)'(mag);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        if (dv_start) state_d = S_DIV;
        else if (last_cell_i) state_d = S_ACC;
      end
      S_DIV:  if (!start_q && dx_done && dy_done) state_d = S_SQ;
      S_SQ:   state_d = S_SQRT;
      S_SQRT: if (!start_q && sq_done) state_d = S_ACC;
      S_ACC:  if (!start_q) state_d = (last_q && count_q != '0 && !out_valid_q) ? S_AVG :
                (last_q && (count_q != '0 || out_valid_q)) ? S_ACC : S_IDLE;
      S_AVG:  if (!start_q && ad_done) state_d = S_RE;
      S_RE:   if (!start_q && rd_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      height_q <= 13'd128;
      visc_q <= 16'd1311;
      sum_q <= '0;
      count_q <= '0;
      fluid_q <= 1'b0;
      last_q <= 1'b0;
      zero_q <= 1'b0;
      start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (state_d != state_q) && (state_d == S_DIV || state_d == S_SQRT ||
                 state_d == S_ACC || state_d == S_AVG || state_d == S_RE);
      if (cfg_we_i) begin
        case (cfg_index_i)
          lbmav_pkg::CfgHeight[0:0]: height_q <= cfg_data_i[12:0];
          default: visc_q <= cfg_data_i;
        endcase
      end
      if (accept) begin
        fluid_q <= dv_start;
        last_q <= last_cell_i;
        zero_q <= (rho == '0);
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      // Fold the magnitude into the running sum once.
      if (state_q == S_ACC && start_q && fluid_q) begin
        sum_q <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
        count_q <= count_q + 1'b1;
        fluid_q <= 1'b0;
      end
      // Empty grid reports without the dividers, once the previous report is taken.
      if (state_q == S_ACC && !start_q && last_q && count_q == '0 && !out_valid_q) begin
        out_valid_q <= 1'b1;
        out_avg_q <= '0;
        out_re_q <= '0;
        out_cnt_q <= '0;
        out_nf_q <= 1'b1;
        last_q <= 1'b0;
      end
      if (state_q == S_RE && !start_q && rd_done) begin
        out_valid_q <= 1'b1;
        out_avg_q <= avg_q;
        out_re_q <= (prod_q == '0) ? '0 : (visc_q == '0) ? '1 :
                    (rd_q[ReNumW-1:32] != '0) ? '1 : rd_q[31:0];
        out_cnt_q <= count_q;
        out_nf_q <= 1'b0;
        sum_q <= '0;
        count_q <= '0;
        last_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && dx_done && dy_done && !start_q) begin
      ux_q <= zero_q ? '0 : qx[16:0];
      uy_q <= zero_q ? '0 : qy[16:0];
    end
    if (state_q == S_SQ) sq_q <= 36'(ux_q) * 36'(ux_q) + 36'(uy_q) * 36'(uy_q);
    if (state_q == S_AVG && ad_done && !start_q) begin
      avg_q <= (ad_q[SumW-1:17] != '0) ? '1 : ad_q[16:0];
      prod_q <= 30'((ad_q[SumW-1:17] != '0) ? 17'h1FFFF : ad_q[16:0]) * 30'(height_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_speed_o = out_avg_q;
  assign reynolds_number_o = out_re_q;
  assign fluid_cells_o = out_cnt_q;
  assign no_fluid_o = out_nf_q;
endmodule
`default_nettype wire

// ===== src/lbmav_divlane.sv =====
// One restoring divider lane: one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lbmav_divlane #(
  parameter int unsigned NumW = 34,
  parameter int unsigned DenW = 20
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  // Shift in the next numerator bit and try the subtract.
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = !busy_q;
  assign quo_o = quo_q;
endmodule
`default_nettype wire

// ===== src/lbmav_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on lbmav_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbmav_sqrt (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [35:0]           rad_i,
  output logic                       done_o,
  output logic [lbmav_pkg::MagW-1:0] root_o
);
  logic [35:0] rad_q, rad_d;
  logic [19:0] rem_q, rem_d;
  logic [17:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [19:0] trial, test;

  // Bring down two bits, compare against 4*root+1.
  always_comb begin
    rad_d = rad_q;
    rem_d = rem_q;
    root_d = root_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[17:0], rad_q[35:34]};
    test = {root_q, 2'b01};
    if (start_i) begin
      rad_d = rad_i;
      rem_d = '0;
      root_d = '0;
      cnt_d = 5'd18;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[33:0], 2'b00};
      if (trial >= test) begin
        rem_d = trial - test;
        root_d = {root_q[16:0], 1'b1};
      end else begin
        rem_d = trial;
        root_d = {root_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign done_o = !busy_q;
  assign root_o = root_q[lbmav_pkg::MagW-1:0];
endmodule
`default_nettype wire
